FILE: rtl/prcrm_pkg.sv
// Shared widths, constants and types for the page reference count region marker.
package prcrm_pkg;

  // Page geometry and request limits
  localparam int PAGE_BITS      = 12;
  localparam int NUM_PAGES      = 4096;
  localparam int MAX_SPAN_PAGES = 64;

  // Field widths
  localparam int ADDR_W     = 24;
  localparam int BYTES_W    = 19;
  localparam int CNT_W      = 16;
  localparam int PAGE_IDX_W = $clog2(NUM_PAGES);
  localparam int RUN_W      = $clog2(MAX_SPAN_PAGES + 1);
  localparam int FIRST_W    = ADDR_W - PAGE_BITS;
  localparam int LAST_W     = ADDR_W + 1 - PAGE_BITS;

  // Result item kinds
  localparam logic KIND_REGION = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [BYTES_W-1:0]    bytes_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [PAGE_IDX_W-1:0] page_idx_t;

  // Result of one count update
  typedef struct packed {
    cnt_t count;
    logic hit;
    logic err;
  } cnt_upd_t;

endpackage

FILE: rtl/prcrm_chan_if.sv
// Valid/ready channel interfaces for requests and result items.
interface prcrm_in_if;
  import prcrm_pkg::*;

  logic   valid;
  logic   ready;
  addr_t  start_address;
  bytes_t range_bytes;
  logic   increment;

  modport source (output valid, start_address, range_bytes, increment, input ready);
  modport sink   (input valid, start_address, range_bytes, increment, output ready);
endinterface

interface prcrm_out_if;
  import prcrm_pkg::*;

  logic   valid;
  logic   ready;
  logic   item_kind;
  addr_t  region_address;
  bytes_t region_bytes;
  logic   now_cached;
  logic   error_flag;
  logic   last_item;

  modport source (output valid, item_kind, region_address, region_bytes, now_cached,
                  error_flag, last_item, input ready);
  modport sink   (input valid, item_kind, region_address, region_bytes, now_cached,
                  error_flag, last_item, output ready);
endinterface

FILE: rtl/prcrm_page_ram.sv
// Page reference count table: one write port, one registered read port.
module prcrm_page_ram (
  input  logic                 clk,
  input  logic                 we,
  input  prcrm_pkg::page_idx_t waddr,
  input  prcrm_pkg::cnt_t      wdata,
  input  prcrm_pkg::page_idx_t raddr,
  output prcrm_pkg::cnt_t      rdata
);
  import prcrm_pkg::*;

  cnt_t mem [NUM_PAGES];
  cnt_t rdata_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/prcrm_cnt_unit.sv
// Shared count update unit: add or remove one reference with saturation check.
module prcrm_cnt_unit (
  input  prcrm_pkg::cnt_t     count,
  input  logic                increment,
  output prcrm_pkg::cnt_upd_t upd
);
  import prcrm_pkg::*;

  localparam cnt_t CNT_MAX = '1;

  always_comb begin
    upd.count = count;
    upd.hit   = 1'b0;
    upd.err   = 1'b0;
    if (increment) begin
      // Hold a full count and flag overflow
      if (count == CNT_MAX) begin
        upd.err = 1'b1;
      end else begin
        upd.count = count + cnt_t'(1);
        upd.hit   = (count == '0);
      end
    end else begin
      // Hold a zero count and flag underflow
      if (count == '0) begin
        upd.err = 1'b1;
      end else begin
        upd.count = count - cnt_t'(1);
        upd.hit   = (count == cnt_t'(1));
      end
    end
  end

endmodule

FILE: rtl/page_refcount_region_marker_core.sv
// Top level: request sequencer, page walk, run coalescing and result register.
//
// Keeps a 16-bit reference count for each of 4096 pages of 4 KiB. After reset
// the block sweeps the count table to zero, one entry per cycle, and holds
// in_chan.ready low meanwhile. A request is taken only in idle; it passes the
// range check, then each covered page gets a table read, then the count update
// and write-back through the single update unit. Each result item waits in the
// output register until the result side takes it, and the walk holds meanwhile.
// At the end of the range the block flushes a run that is still open, then sets
// up the done item, and returns to idle, ready for the next request, once the
// done item is taken.
// The walk is bounded by the one read and one write port of the count table.
// Runs of pages that became cached (count now one) or uncached (count now
// zero) are reported as regions; a done item ends every request, its error
// flag set on a count overflow or underflow, and a rejected range yields only
// that done item, with the error flag set.
module page_refcount_region_marker_core (
  input logic        clk,
  input logic        rst_n,
  prcrm_in_if.sink   in_chan,
  prcrm_out_if.source out_chan
);
  import prcrm_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_TAIL = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  page_idx_t        clr_idx_r, clr_idx_nxt;
  page_idx_t        page_r, page_nxt;
  page_idx_t        last_r, last_nxt;
  logic             at_end_r, at_end_nxt;
  logic             inc_r, inc_nxt;
  addr_t            addr_r, addr_nxt;
  bytes_t           size_r, size_nxt;
  page_idx_t        run_start_r, run_start_nxt;
  logic [RUN_W-1:0] run_pages_r, run_pages_nxt;
  logic             err_r, err_nxt;

  logic   out_valid_r, out_valid_nxt;
  logic   out_kind_r, out_kind_nxt;
  addr_t  out_addr_r, out_addr_nxt;
  bytes_t out_bytes_r, out_bytes_nxt;
  logic   out_cached_r, out_cached_nxt;
  logic   out_err_r, out_err_nxt;
  logic   out_last_r, out_last_nxt;

  logic      ram_we;
  page_idx_t ram_waddr;
  cnt_t      ram_wdata;
  cnt_t      ram_rdata;
  cnt_upd_t  upd;

  logic [ADDR_W:0]    end_addr;
  logic [LAST_W-1:0]  last_page;
  logic [FIRST_W-1:0] first_page;
  logic [LAST_W-1:0]  span_m1;
  logic               bad_range;

  prcrm_page_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (page_r),
    .rdata (ram_rdata)
  );

  prcrm_cnt_unit u_cnt (
    .count     (ram_rdata),
    .increment (inc_r),
    .upd       (upd)
  );

  // Range check on the latched request
  assign end_addr   = (ADDR_W+1)'(addr_r) + (ADDR_W+1)'(size_r) - (ADDR_W+1)'(1);
  assign last_page  = end_addr[ADDR_W:PAGE_BITS];
  assign first_page = addr_r[ADDR_W-1:PAGE_BITS];
  assign span_m1    = last_page - LAST_W'(first_page);
  assign bad_range  = (size_r == '0) || (last_page >= LAST_W'(NUM_PAGES)) ||
                      (span_m1 >= LAST_W'(MAX_SPAN_PAGES));

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    page_nxt       = page_r;
    last_nxt       = last_r;
    at_end_nxt     = at_end_r;
    inc_nxt        = inc_r;
    addr_nxt       = addr_r;
    size_nxt       = size_r;
    run_start_nxt  = run_start_r;
    run_pages_nxt  = run_pages_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_addr_nxt   = out_addr_r;
    out_bytes_nxt  = out_bytes_r;
    out_cached_nxt = out_cached_r;
    out_err_nxt    = out_err_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = page_r;
    ram_wdata      = upd.count;

    unique case (state_r)
      S_CLR: begin
        // Zero the table one entry per cycle
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + page_idx_t'(1);
        if (clr_idx_r == page_idx_t'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          addr_nxt      = in_chan.start_address;
          size_nxt      = in_chan.range_bytes;
          inc_nxt       = in_chan.increment;
          err_nxt       = 1'b0;
          run_pages_nxt = '0;
          state_nxt     = S_CHK;
        end
      end
      S_CHK: begin
        if (bad_range) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_DONE;
          out_addr_nxt   = '0;
          out_bytes_nxt  = '0;
          out_cached_nxt = 1'b0;
          out_err_nxt    = 1'b1;
          out_last_nxt   = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          page_nxt   = page_idx_t'(first_page);
          last_nxt   = page_idx_t'(last_page);
          at_end_nxt = 1'b0;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // Write back the updated count and advance the page
        ram_we     = 1'b1;
        at_end_nxt = (page_r == last_r);
        page_nxt   = page_r + page_idx_t'(1);
        err_nxt    = err_r | upd.err;
        if (upd.hit) begin
          if (run_pages_r == '0) begin
            run_start_nxt = page_r;
          end
          run_pages_nxt = run_pages_r + RUN_W'(1);
          state_nxt     = (page_r == last_r) ? S_TAIL : S_RD;
        end else if (run_pages_r != '0) begin
          // Run breaks here: report it
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_REGION;
          out_addr_nxt   = ADDR_W'({run_start_r, PAGE_BITS'(0)});
          out_bytes_nxt  = BYTES_W'({run_pages_r, PAGE_BITS'(0)});
          out_cached_nxt = inc_r;
          out_err_nxt    = 1'b0;
          out_last_nxt   = 1'b0;
          run_pages_nxt  = '0;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = (page_r == last_r) ? S_TAIL : S_RD;
        end
      end
      S_TAIL: begin
        // Flush an open run, else finish with the done item
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
        if (run_pages_r != '0) begin
          out_kind_nxt   = KIND_REGION;
          out_addr_nxt   = ADDR_W'({run_start_r, PAGE_BITS'(0)});
          out_bytes_nxt  = BYTES_W'({run_pages_r, PAGE_BITS'(0)});
          out_cached_nxt = inc_r;
          out_err_nxt    = 1'b0;
          out_last_nxt   = 1'b0;
          run_pages_nxt  = '0;
        end else begin
          out_kind_nxt   = KIND_DONE;
          out_addr_nxt   = '0;
          out_bytes_nxt  = '0;
          out_cached_nxt = 1'b0;
          out_err_nxt    = err_r;
          out_last_nxt   = 1'b1;
        end
      end
      S_OUT: begin
        // Hold the result until its transfer
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          if (out_kind_r == KIND_DONE) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = at_end_r ? S_TAIL : S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      run_pages_r <= '0;
      err_r       <= 1'b0;
      at_end_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      run_pages_r <= run_pages_nxt;
      err_r       <= err_nxt;
      at_end_r    <= at_end_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    last_r       <= last_nxt;
    inc_r        <= inc_nxt;
    addr_r       <= addr_nxt;
    size_r       <= size_nxt;
    run_start_r  <= run_start_nxt;
    out_kind_r   <= out_kind_nxt;
    out_addr_r   <= out_addr_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_cached_r <= out_cached_nxt;
    out_err_r    <= out_err_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.item_kind      = out_kind_r;
  assign out_chan.region_address = out_addr_r;
  assign out_chan.region_bytes   = out_bytes_r;
  assign out_chan.now_cached     = out_cached_r;
  assign out_chan.error_flag     = out_err_r;
  assign out_chan.last_item      = out_last_r;

`ifndef SYNTH
  a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    run_pages_r <= RUN_W'(MAX_SPAN_PAGES))
    else $error("run length exceeds span limit");

  a_region_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_REGION) |-> (out_bytes_r != '0 && !out_last_r))
    else $error("region item with no pages or marked last");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan.ready && out_kind_r == KIND_DONE) |=> (state_r == S_IDLE))
    else $error("done transfer did not return to idle");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (page_r <= last_r))
    else $error("page walk ran past the last page");
`endif

endmodule
